>>> design/sgch_pkg.sv
// ============================================================================
// sgch_pkg: shared types, constants and helpers
// Field widths, register indexes, action codes and the channel quantizer used
// by the superpixel gradient and colour histogram block.
// ============================================================================
package sgch_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int NUM_SUPERPIXELS_DEF = 1024;
  localparam int ORIENT_BINS_DEF     = 8;
  localparam int COLOR_LEVELS_DEF    = 4;
  localparam int MAX_PIXELS_DEF      = 1024;

  // Field widths.
  localparam int SP_W        = 10;
  localparam int ANGLE_W     = 15;
  localparam int MAG_W       = 17;
  localparam int CH_W        = 8;
  localparam int STEP_W      = 9;
  localparam int SEL_W       = 6;
  localparam int SUM_W       = 27;
  localparam int COUNT_W     = 11;
  localparam int LVL_W       = 2;
  localparam int CBIN_W      = 6;
  localparam int ADDR_W      = 16;
  localparam int ACW         = SP_W + 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_STEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RED_STEP   = 3'd6;

  typedef enum logic [1:0] {
    ACT_CLEAR       = 2'd0,
    ACT_ACCUM       = 2'd1,
    ACT_READ_ORIENT = 2'd2,
    ACT_READ_COLOR  = 2'd3
  } action_e;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_step;
    logic [CH_W-1:0]    blue_min;
    logic [CH_W-1:0]    green_min;
    logic [CH_W-1:0]    red_min;
    logic [STEP_W-1:0]  blue_step;
    logic [STEP_W-1:0]  green_step;
    logic [STEP_W-1:0]  red_step;
  } cfg_t;

  // One classified command, as passed from the front end to the back end.
  typedef struct packed {
    action_e           kind;
    logic              read_zero;
    logic [ADDR_W-1:0] oaddr;
    logic [ADDR_W-1:0] caddr;
    logic [MAG_W-1:0]  mag;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic pop;
    logic read_land;
  } back_status_t;

  // Channel bin: ceil((v - lo) / step) clamped to levels-1, zero when v <= lo.
  // The bin is at least k exactly when (v - lo) exceeds (k-1) steps.
  function automatic logic [LVL_W-1:0] quant_channel(input logic [CH_W-1:0]   v,
                                                     input logic [CH_W-1:0]   lo,
                                                     input logic [STEP_W-1:0] step,
                                                     input int                levels);
    logic [STEP_W-1:0] s;
    logic [STEP_W:0]   s2;
    logic [CH_W-1:0]   d;
    logic [LVL_W-1:0]  q;
    s  = (step == '0) ? STEP_W'(1) : step;
    s2 = {s, 1'b0};
    d  = (v > lo) ? CH_W'(v - lo) : '0;
    q  = '0;
    if ((d != '0) && (levels > 1)) q = LVL_W'(1);
    if ((STEP_W'(d) > s) && (levels > 2)) q = LVL_W'(2);
    if (((STEP_W + 1)'(d) > s2) && (levels > 3)) q = LVL_W'(3);
    return q;
  endfunction

endpackage

>>> design/superpixel_gradient_color_histogram.sv
// ============================================================================
// superpixel_gradient_color_histogram: per-superpixel gradient and colour
// histograms
// Accumulates magnitude-weighted orientation bins and joint colour bins for
// every superpixel label, with clear and single-bin read transactions.
// ============================================================================
// Each input transaction carries an action in tuser: clear a superpixel, add
// a pixel to it, or read one orientation or colour bin (the only actions that
// return a transaction). The histogram memories have no defined contents
// after reset and there is no clearing pass, so every superpixel must be
// cleared before it is accumulated into or read. The front end takes an item,
// passes pixels through its one-bit-per-cycle orientation divider and then
// hands the command on, taking no new item until the command is queued;
// clears and reads skip the divider. The back end reads the memories, then
// writes back for a pixel or fills the result register for a read, and it
// sweeps a clear over max(ORIENT_BINS, COLOR_LEVELS^3) bins, zeroing one bin
// of each memory per cycle; a four-entry queue between the two lets the front
// end carry on while a clear is swept. The result register frees the back
// end from the result consumer, but a read waits at the head of the queue
// while a previous result is still untaken. Configuration writes are
// accepted every cycle and must only be issued while the block is idle;
// out-of-range labels and bins read as zero.
// ============================================================================
module superpixel_gradient_color_histogram #(
  parameter int NUM_SUPERPIXELS = sgch_pkg::NUM_SUPERPIXELS_DEF,
  parameter int ORIENT_BINS     = sgch_pkg::ORIENT_BINS_DEF,
  parameter int COLOR_LEVELS    = sgch_pkg::COLOR_LEVELS_DEF,
  parameter int MAX_PIXELS      = sgch_pkg::MAX_PIXELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Pixel, clear and read transactions.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: superpixel[9:0], angle[24:10], magnitude[41:25],
  // blue[49:42], green[57:50], red[65:58], bin_select[71:66]
  input  logic [sgch_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                         s_axis_tuser,
  // Bin read results.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: bin_value[26:0], zero padding[31:27]
  output logic [sgch_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sgch_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sgch_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sgch_pkg::*;

  cfg_t          cfg_q;
  logic          q_push, q_pop;
  cmd_t          front_cmd, head_cmd;
  queue_status_t q_status;
  back_status_t  b_status;
  logic [SUM_W-1:0] bin_value;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are
  // dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_step <= ANGLE_W'(2880);
      cfg_q.blue_min   <= '0;
      cfg_q.green_min  <= '0;
      cfg_q.red_min    <= '0;
      cfg_q.blue_step  <= STEP_W'(64);
      cfg_q.green_step <= STEP_W'(64);
      cfg_q.red_step   <= STEP_W'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ANGLE_STEP: cfg_q.angle_step <= cfg_data_i[ANGLE_W-1:0];
        REG_BLUE_MIN:   cfg_q.blue_min   <= cfg_data_i[CH_W-1:0];
        REG_GREEN_MIN:  cfg_q.green_min  <= cfg_data_i[CH_W-1:0];
        REG_RED_MIN:    cfg_q.red_min    <= cfg_data_i[CH_W-1:0];
        REG_BLUE_STEP:  cfg_q.blue_step  <= cfg_data_i[STEP_W-1:0];
        REG_GREEN_STEP: cfg_q.green_step <= cfg_data_i[STEP_W-1:0];
        REG_RED_STEP:   cfg_q.red_step   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front end: unpacks the transaction, works out bins and addresses.
  // --------------------------------------------------------------------------
  sgch_front #(
    .NUM_SUPERPIXELS (NUM_SUPERPIXELS),
    .ORIENT_BINS     (ORIENT_BINS),
    .COLOR_LEVELS    (COLOR_LEVELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (action_e'(s_axis_tuser)),
    .superpixel_i (s_axis_tdata[9:0]),
    .angle_i      (s_axis_tdata[24:10]),
    .magnitude_i  (s_axis_tdata[41:25]),
    .blue_i       (s_axis_tdata[49:42]),
    .green_i      (s_axis_tdata[57:50]),
    .red_i        (s_axis_tdata[65:58]),
    .bin_select_i (s_axis_tdata[71:66]),
    .queue_full_i (q_status.full),
    .push_o       (q_push),
    .cmd_o        (front_cmd)
  );

  // --------------------------------------------------------------------------
  // Command queue decoupling the two ends.
  // --------------------------------------------------------------------------
  sgch_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .cmd_i    (front_cmd),
    .pop_i    (q_pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // --------------------------------------------------------------------------
  // Back end: histogram memories, updates, clears and the result register.
  // --------------------------------------------------------------------------
  sgch_back #(
    .NUM_SUPERPIXELS (NUM_SUPERPIXELS),
    .ORIENT_BINS     (ORIENT_BINS),
    .COLOR_LEVELS    (COLOR_LEVELS),
    .MAX_PIXELS      (MAX_PIXELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .queue_status_i (q_status),
    .pop_o          (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (bin_value),
    .status_o       (b_status)
  );

  assign m_axis_tdata = OUT_TDATA_W'(bin_value);

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The front end never pushes into a full queue.
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("command pushed into a full queue");

  // The back end never takes a command from an empty queue.
  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.pop |-> !q_status.empty)
    else $error("command popped from an empty queue");

  // Read data only lands when the result register is free.
  a_read_lands_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.read_land |-> !m_axis_tvalid)
    else $error("read result would overwrite a pending result");

  // Every landed read is presented on the next cycle.
  a_read_presented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.read_land |=> m_axis_tvalid)
    else $error("read result not presented");

endmodule

>>> design/sgch_ram.sv
// ============================================================================
// sgch_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module sgch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sgch_front.sv
// ============================================================================
// sgch_front: item acceptance and classification
// Takes one item, finds its orientation bin with a short restoring divider,
// quantizes the colour, forms the histogram addresses and queues a command.
// ============================================================================
module sgch_front #(
  parameter int NUM_SUPERPIXELS = 1024,
  parameter int ORIENT_BINS     = 8,
  parameter int COLOR_LEVELS    = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sgch_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sgch_pkg::action_e            action_i,
  input  logic [sgch_pkg::SP_W-1:0]    superpixel_i,
  input  logic [sgch_pkg::ANGLE_W-1:0] angle_i,
  input  logic [sgch_pkg::MAG_W-1:0]   magnitude_i,
  input  logic [sgch_pkg::CH_W-1:0]    blue_i,
  input  logic [sgch_pkg::CH_W-1:0]    green_i,
  input  logic [sgch_pkg::CH_W-1:0]    red_i,
  input  logic [sgch_pkg::SEL_W-1:0]   bin_select_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output sgch_pkg::cmd_t               cmd_o
);
  import sgch_pkg::*;

  localparam int OBW        = (ORIENT_BINS > 1) ? $clog2(ORIENT_BINS) : 1;
  localparam int CW         = (OBW > 1) ? $clog2(OBW) : 1;
  localparam int DIV_W      = ANGLE_W + OBW;
  localparam int COLOR_BINS = COLOR_LEVELS * COLOR_LEVELS * COLOR_LEVELS;
  localparam logic [SP_W:0] SP_LIM = (NUM_SUPERPIXELS >= 2 ** SP_W) ?
                                     (SP_W + 1)'(2 ** SP_W) : (SP_W + 1)'(NUM_SUPERPIXELS);
  localparam logic [OBW-1:0]    OB_LAST = OBW'(ORIENT_BINS - 1);
  localparam logic [CBIN_W-1:0] L1      = CBIN_W'(COLOR_LEVELS);
  localparam logic [CBIN_W-1:0] L2      = CBIN_W'(COLOR_LEVELS * COLOR_LEVELS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e            state_q, state_d;
  action_e            action_q;
  logic [SP_W-1:0]    sp_q;
  logic               sp_ok_q;
  logic [MAG_W-1:0]   mag_q;
  logic [CH_W-1:0]    blue_q, green_q, red_q;
  logic [SEL_W-1:0]   sel_q;
  logic               over_q;
  logic [ANGLE_W-1:0] rem_q;
  logic [DIV_W-1:0]   div_q;
  logic [OBW-1:0]     quo_q;
  logic [CW-1:0]      cnt_q;

  logic [ANGLE_W-1:0] step_eff;
  logic               accept, sp_ok_in, ge;
  logic [OBW-1:0]     ob;
  logic [CBIN_W-1:0]  cb;
  logic [SEL_W-1:0]   ooff;
  logic [CBIN_W-1:0]  coff;

  assign step_eff   = (cfg_i.angle_step == '0) ? ANGLE_W'(1) : cfg_i.angle_step;
  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign sp_ok_in   = ({1'b0, superpixel_i} < SP_LIM);
  assign ge         = (DIV_W'(rem_q) >= div_q);
  assign push_o     = (state_q == F_PUSH) && !queue_full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (((action_i == ACT_CLEAR) || (action_i == ACT_ACCUM)) && !sp_ok_in) begin
            state_d = F_IDLE;
          end else if (action_i == ACT_ACCUM) begin
            state_d = F_DIV;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        if (cnt_q == '0) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_o) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item registers and divider datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      sp_q     <= superpixel_i;
      sp_ok_q  <= sp_ok_in;
      mag_q    <= magnitude_i;
      blue_q   <= blue_i;
      green_q  <= green_i;
      red_q    <= red_i;
      sel_q    <= bin_select_i;
      rem_q    <= angle_i;
      div_q    <= DIV_W'(step_eff) << (OBW - 1);
      quo_q    <= '0;
      cnt_q    <= CW'(OBW - 1);
      over_q   <= (DIV_W'(angle_i) >= (DIV_W'(step_eff) << OBW));
    end else if (state_q == F_DIV) begin
      if (ge) rem_q <= rem_q - ANGLE_W'(div_q);
      quo_q <= OBW'({quo_q, ge});
      div_q <= div_q >> 1;
      cnt_q <= cnt_q - CW'(1);
    end
  end

  assign ob = (over_q || (quo_q > OB_LAST)) ? OB_LAST : quo_q;
  assign cb = CBIN_W'(quant_channel(blue_q, cfg_i.blue_min, cfg_i.blue_step, COLOR_LEVELS))
            + L1 * CBIN_W'(quant_channel(green_q, cfg_i.green_min, cfg_i.green_step,
                                         COLOR_LEVELS))
            + L2 * CBIN_W'(quant_channel(red_q, cfg_i.red_min, cfg_i.red_step, COLOR_LEVELS));

  always_comb begin
    ooff = '0;
    coff = '0;
    case (action_q)
      ACT_ACCUM: begin
        ooff = SEL_W'(ob);
        coff = cb;
      end
      ACT_READ_ORIENT: ooff = sel_q;
      ACT_READ_COLOR:  coff = CBIN_W'(sel_q);
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.kind  = action_q;
    cmd_o.mag   = mag_q;
    cmd_o.oaddr = ADDR_W'(ACW'(sp_q) * ACW'(ORIENT_BINS) + ACW'(ooff));
    cmd_o.caddr = ADDR_W'(ACW'(sp_q) * ACW'(COLOR_BINS) + ACW'(coff));
    case (action_q)
      ACT_READ_ORIENT: cmd_o.read_zero = !sp_ok_q || (8'(sel_q) >= 8'(ORIENT_BINS));
      ACT_READ_COLOR:  cmd_o.read_zero = !sp_ok_q || (8'(sel_q) >= 8'(COLOR_BINS));
      default:         cmd_o.read_zero = 1'b0;
    endcase
  end

endmodule

>>> design/sgch_queue.sv
// ============================================================================
// sgch_queue: command queue between front and back end
// A small FIFO of classified commands so that either side can stall alone.
// ============================================================================
module sgch_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sgch_pkg::cmd_t          cmd_i,
  input  logic                    pop_i,
  output sgch_pkg::cmd_t          cmd_o,
  output sgch_pkg::queue_status_t status_o
);
  import sgch_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + PW'(1));
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= next_ptr(wptr_q);
      if (pop_i)  rptr_q <= next_ptr(rptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign cmd_o          = entries_q[rptr_q];
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

>>> design/sgch_back.sv
// ============================================================================
// sgch_back: histogram execution
// Runs clears, read-modify-write updates and bin reads against the two
// histogram memories, and holds the result in an output register.
// ============================================================================
module sgch_back #(
  parameter int NUM_SUPERPIXELS = 1024,
  parameter int ORIENT_BINS     = 8,
  parameter int COLOR_LEVELS    = 4,
  parameter int MAX_PIXELS      = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sgch_pkg::cmd_t             cmd_i,
  input  sgch_pkg::queue_status_t    queue_status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sgch_pkg::SUM_W-1:0] out_data_o,
  output sgch_pkg::back_status_t     status_o
);
  import sgch_pkg::*;

  localparam int NSP_EFF    = (NUM_SUPERPIXELS < 2 ** SP_W) ? NUM_SUPERPIXELS : 2 ** SP_W;
  localparam int COLOR_BINS = COLOR_LEVELS * COLOR_LEVELS * COLOR_LEVELS;
  localparam int O_DEPTH    = NSP_EFF * ORIENT_BINS;
  localparam int C_DEPTH    = NSP_EFF * COLOR_BINS;
  localparam int OAW        = (O_DEPTH > 1) ? $clog2(O_DEPTH) : 1;
  localparam int CAW        = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
  localparam int MAXB       = (ORIENT_BINS > COLOR_BINS) ? ORIENT_BINS : COLOR_BINS;
  localparam int CLR_W      = (MAXB > 1) ? $clog2(MAXB) : 1;
  localparam logic [COUNT_W-1:0] PIX_LIM = COUNT_W'(MAX_PIXELS);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_ACCUM = 4'b0010,
    B_READ  = 4'b0100,
    B_CLEAR = 4'b1000
  } bstate_e;

  bstate_e            state_q, state_d;
  cmd_t               cmd_q;
  logic [CLR_W-1:0]   clr_q;
  logic               out_valid_q;
  logic [SUM_W-1:0]   out_data_q;

  logic               is_read, clearing, accum;
  logic [SUM_W-1:0]   o_rdata, o_wdata;
  logic [COUNT_W-1:0] c_rdata, c_wdata;
  logic [SUM_W:0]     osum;
  logic               o_we, c_we;
  logic [ADDR_W-1:0]  o_waddr, c_waddr, clr_off;

  assign is_read  = (cmd_i.kind == ACT_READ_ORIENT) || (cmd_i.kind == ACT_READ_COLOR);
  assign pop_o    = (state_q == B_IDLE) && !queue_status_i.empty && (!is_read || !out_valid_q);
  assign clearing = (state_q == B_CLEAR);
  assign accum    = (state_q == B_ACCUM);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          unique case (cmd_i.kind) inside
            ACT_CLEAR:                       state_d = B_CLEAR;
            ACT_ACCUM:                       state_d = B_ACCUM;
            ACT_READ_ORIENT, ACT_READ_COLOR: state_d = B_READ;
            default:                         state_d = B_IDLE;
          endcase
        end
      end
      B_ACCUM: state_d = B_IDLE;
      B_READ:  state_d = B_IDLE;
      B_CLEAR: begin
        if (clr_q == CLR_W'(MAXB - 1)) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_READ) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + CLR_W'(1);
    end
    if (state_q == B_READ) begin
      if (cmd_q.read_zero) begin
        out_data_q <= '0;
      end else if (cmd_q.kind == ACT_READ_ORIENT) begin
        out_data_q <= o_rdata;
      end else begin
        out_data_q <= SUM_W'(c_rdata);
      end
    end
  end

  // Saturating updates of the bins read in the previous cycle.
  assign osum    = (SUM_W + 1)'(o_rdata) + (SUM_W + 1)'(cmd_q.mag);
  assign clr_off = clearing ? ADDR_W'(clr_q) : '0;
  assign o_waddr = cmd_q.oaddr + clr_off;
  assign c_waddr = cmd_q.caddr + clr_off;
  assign o_we    = accum || (clearing && (8'(clr_q) < 8'(ORIENT_BINS)));
  assign c_we    = accum || (clearing && (8'(clr_q) < 8'(COLOR_BINS)));
  assign o_wdata = clearing ? '0 : ((osum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : osum[SUM_W-1:0]);
  assign c_wdata = clearing ? '0 : ((c_rdata < PIX_LIM) ? c_rdata + COUNT_W'(1) : c_rdata);

  sgch_ram #(
    .WIDTH (SUM_W),
    .DEPTH (O_DEPTH),
    .AW    (OAW)
  ) u_orient_ram (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_waddr[OAW-1:0]),
    .wdata_i (o_wdata),
    .raddr_i (cmd_i.oaddr[OAW-1:0]),
    .rdata_o (o_rdata)
  );

  sgch_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (C_DEPTH),
    .AW    (CAW)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr[CAW-1:0]),
    .wdata_i (c_wdata),
    .raddr_i (cmd_i.caddr[CAW-1:0]),
    .rdata_o (c_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;
  assign status_o.pop       = pop_o;
  assign status_o.read_land = (state_q == B_READ);

endmodule

>>> tb/superpixel_gradient_color_histogram_test.sv
`timescale 1ns / 1ps
// ============================================================================
// superpixel_gradient_color_histogram_test: self-checking testbench
// Drives clear, pixel and bin read transactions into the histogram block,
// predicts every bin read from its own copy of both histograms, and compares
// each returned transaction with the oldest prediction still waiting.
// ============================================================================
module superpixel_gradient_color_histogram_test;
  import sgch_pkg::*;

  // Sizing of the instance under test; the predictor is built to the same.
  localparam int unsigned NUM_LABELS  = NUM_SUPERPIXELS_DEF;
  localparam int unsigned ORIENT_N    = ORIENT_BINS_DEF;
  localparam int unsigned LEVELS      = COLOR_LEVELS_DEF;
  localparam int unsigned COLOR_N     = LEVELS * LEVELS * LEVELS;
  localparam int unsigned PIXEL_CAP   = MAX_PIXELS_DEF;
  localparam int unsigned SUM_CAP     = (1 << SUM_W) - 1;
  localparam int unsigned ANGLE_TOP   = 23039;
  localparam int unsigned MAG_TOP     = (1 << MAG_W) - 1;

  // A clear occupies the back end for a sweep over every colour bin and up to
  // four more may sit in the queue, so this comfortably covers a full drain.
  localparam int unsigned SETTLE_CYCLES    = 400;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned RANDOM_PER_PHASE = 71;
  localparam int unsigned NUM_PHASES       = 6;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned N_ROWS           = 26;

  typedef struct {
    action_e            act;
    logic [SP_W-1:0]    sp;
    logic [ANGLE_W-1:0] angle;
    logic [MAG_W-1:0]   mag;
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    red;
    logic [SEL_W-1:0]   sel;
  } hist_item_t;

  // One row of the directed sequence. When typed is set, the bin value read
  // back is expected to be the one written in the row rather than the predicted one.
  typedef struct packed {
    action_e            act;
    logic [SP_W-1:0]    sp;
    logic [ANGLE_W-1:0] angle;
    logic [MAG_W-1:0]   mag;
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    red;
    logic [SEL_W-1:0]   sel;
    int unsigned        reps;
    logic               typed;
    logic [SUM_W-1:0]   bin_value;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  superpixel_gradient_color_histogram dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predicted histogram state and configuration
  // --------------------------------------------------------------------------
  // The block's memories are undefined until a label is cleared, so only
  // labels in live_labels are ever accumulated into or read.
  logic [SUM_W-1:0]   orient_sum  [NUM_LABELS * ORIENT_N];
  logic [COUNT_W-1:0] color_count [NUM_LABELS * COLOR_N];
  bit                 label_cleared [NUM_LABELS];
  logic [SP_W-1:0]    live_labels [$];

  // Index 0 is blue, 1 green, 2 red, as on the register map.
  logic [ANGLE_W-1:0] cur_angle_step = ANGLE_W'(2880);
  logic [CH_W-1:0]    cur_min  [3]   = '{default: '0};
  logic [STEP_W-1:0]  cur_step [3]   = '{default: STEP_W'(64)};

  logic [SUM_W-1:0]   pending_bin_values [$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;

  // Shared between the sender and the receiver: quiet suppresses idling on
  // both sides for a stretch, hold_rx asks the receiver for a long stall.
  bit quiet   = 1'b0;
  bit hold_rx = 1'b0;

  // Channel level: zero at or below the floor, otherwise the ceiling of the
  // distance over the step, held to the top level. A zero step counts as one.
  function automatic int unsigned channel_level(input int unsigned v, input int unsigned lo,
                                                input int unsigned step);
    int unsigned s;
    int unsigned q;
    s = (step == 0) ? 1 : step;
    if (v <= lo) return 0;
    q = (v - lo + s - 1) / s;
    return (q > LEVELS - 1) ? LEVELS - 1 : q;
  endfunction

  // Applies one accepted transaction to the predicted histograms and says
  // whether it returns a bin value, and which.
  function automatic void update_histograms(input hist_item_t it, output bit yields,
                                            output logic [SUM_W-1:0] value);
    int unsigned astep;
    int unsigned obin;
    int unsigned cbin;
    int unsigned oidx;
    int unsigned cidx;
    int unsigned cur;
    bit          in_range;
    in_range = (int'(it.sp) < NUM_LABELS);
    yields   = 1'b0;
    value    = '0;
    case (it.act)
      ACT_CLEAR: begin
        if (in_range) begin
          for (int b = 0; b < ORIENT_N; b++) orient_sum[it.sp * ORIENT_N + b] = '0;
          for (int b = 0; b < COLOR_N; b++) color_count[it.sp * COLOR_N + b] = '0;
          if (!label_cleared[it.sp]) begin
            label_cleared[it.sp] = 1'b1;
            live_labels.insert(live_labels.size(), it.sp);
          end
        end
      end
      ACT_ACCUM: begin
        if (in_range) begin
          astep = (cur_angle_step == '0) ? 1 : int'(cur_angle_step);
          obin  = int'(it.angle) / astep;
          if (obin > ORIENT_N - 1) obin = ORIENT_N - 1;
          oidx  = it.sp * ORIENT_N + obin;
          cur   = orient_sum[oidx];
          orient_sum[oidx] = (cur > SUM_CAP - it.mag) ? SUM_W'(SUM_CAP) : SUM_W'(cur + it.mag);
          cbin  = channel_level(it.blue, cur_min[0], cur_step[0])
                + LEVELS * channel_level(it.green, cur_min[1], cur_step[1])
                + LEVELS * LEVELS * channel_level(it.red, cur_min[2], cur_step[2]);
          cidx  = it.sp * COLOR_N + cbin;
          if (color_count[cidx] < PIXEL_CAP) color_count[cidx] = color_count[cidx] + 1'b1;
        end
      end
      ACT_READ_ORIENT: begin
        yields = 1'b1;
        if (in_range && (it.sel < ORIENT_N)) value = orient_sum[it.sp * ORIENT_N + it.sel];
      end
      default: begin
        yields = 1'b1;
        if (in_range && (it.sel < COLOR_N)) value = SUM_W'(color_count[it.sp * COLOR_N + it.sel]);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offers one transaction after a random gap. tvalid is only lowered when a
  // gap follows, so back-to-back items never see two assignments in a step.
  task automatic send_item(input hist_item_t it, input logic typed,
                           input logic [SUM_W-1:0] typed_value);
    int unsigned      gap;
    bit               yields;
    logic [SUM_W-1:0] value;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.sel, it.red, it.green, it.blue, it.mag, it.angle, it.sp};
    s_axis_tuser  <= it.act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    update_histograms(it, yields, value);
    if (yields) begin
      pending_bin_values.insert(pending_bin_values.size(), typed ? typed_value : value);
    end
  endtask

  // Writes one register; cfg_valid_i is dropped by the caller after a burst.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ANGLE_STEP: cur_angle_step = data[ANGLE_W-1:0];
      REG_BLUE_MIN:   cur_min[0]     = data[CH_W-1:0];
      REG_GREEN_MIN:  cur_min[1]     = data[CH_W-1:0];
      REG_RED_MIN:    cur_min[2]     = data[CH_W-1:0];
      REG_BLUE_STEP:  cur_step[0]    = data[STEP_W-1:0];
      REG_GREEN_STEP: cur_step[1]    = data[STEP_W-1:0];
      REG_RED_STEP:   cur_step[2]    = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_ANGLE_STEP, CFG_DATA_W'(c.angle_step));
    write_reg(REG_BLUE_MIN,   CFG_DATA_W'(c.blue_min));
    write_reg(REG_GREEN_MIN,  CFG_DATA_W'(c.green_min));
    write_reg(REG_RED_MIN,    CFG_DATA_W'(c.red_min));
    write_reg(REG_BLUE_STEP,  CFG_DATA_W'(c.blue_step));
    write_reg(REG_GREEN_STEP, CFG_DATA_W'(c.green_step));
    write_reg(REG_RED_STEP,   CFG_DATA_W'(c.red_step));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering, waits for every predicted read to come back and then lets
  // any clear or pixel still in flight finish, so the block is truly idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_bin_values.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Favours the few most recently cleared labels so that their bins build up
  // real counts, while still wandering over the whole live set.
  function automatic logic [SP_W-1:0] pick_live_label();
    int unsigned n;
    n = live_labels.size();
    if (n > 4 && $urandom_range(0, 1) == 0) return live_labels[n - 1 - $urandom_range(0, 3)];
    return live_labels[$urandom_range(0, n - 1)];
  endfunction

  // Random transaction: mostly pixels and reads on cleared labels, with
  // occasional clears of fresh labels (or re-clears of live ones). Fields an
  // action does not use still carry random content.
  function automatic hist_item_t random_item();
    hist_item_t  it;
    int unsigned roll;
    it.sp    = SP_W'($urandom_range(0, NUM_LABELS - 1));
    it.angle = ANGLE_W'($urandom_range(0, ANGLE_TOP));
    it.mag   = ($urandom_range(0, 7) == 0) ? MAG_W'(MAG_TOP - $urandom_range(0, 15))
                                           : MAG_W'($urandom);
    it.blue  = CH_W'($urandom);
    it.green = CH_W'($urandom);
    it.red   = CH_W'($urandom);
    it.sel   = SEL_W'($urandom);
    roll     = $urandom_range(0, 99);
    if (live_labels.size() == 0 || roll < 8) begin
      it.act = ACT_CLEAR;
      if (live_labels.size() != 0 && roll < 3) it.sp = pick_live_label();
    end else if (roll < 60) begin
      it.act = ACT_ACCUM;
      it.sp  = pick_live_label();
    end else if (roll < 80) begin
      it.act = ACT_READ_ORIENT;
      it.sp  = pick_live_label();
      // Mostly real orientation bins, sometimes beyond the last one.
      if ($urandom_range(0, 4) != 0) it.sel = SEL_W'($urandom_range(0, ORIENT_N - 1));
    end else begin
      it.act = ACT_READ_COLOR;
      it.sp  = pick_live_label();
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Directed sequence
  // --------------------------------------------------------------------------
  // Under the reset configuration: angle bins are 2880 wide, so 23039 lands
  // in bin 7, and colour channels of 255 quantize to level 3, giving colour
  // bin 63. The long row pushes 200 full-scale pixels into one label so that
  // its top orientation and colour bins build up large totals.
  stim_row_t directed_rows [N_ROWS] = '{
    '{ACT_CLEAR,       10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b0, 27'd0},
    '{ACT_CLEAR,       10'd1023, 15'd23039, 17'd131071, 8'd255, 8'd255, 8'd255, 6'd63, 1, 1'b0, 27'd0},
    '{ACT_READ_ORIENT, 10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b1, 27'd0},
    '{ACT_READ_COLOR,  10'd1023, 15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd63, 1, 1'b1, 27'd0},
    '{ACT_ACCUM,       10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b0, 27'd0},
    '{ACT_ACCUM,       10'd0,    15'd23039, 17'd131071, 8'd255, 8'd255, 8'd255, 6'd0,  1, 1'b0, 27'd0},
    '{ACT_READ_ORIENT, 10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd7,  1, 1'b1,
      27'd131071},
    '{ACT_READ_COLOR,  10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd63, 1, 1'b1, 27'd1},
    '{ACT_READ_COLOR,  10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b1, 27'd1},
    // Orientation reads past the last bin return zero.
    '{ACT_READ_ORIENT, 10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd8,  1, 1'b1, 27'd0},
    '{ACT_READ_ORIENT, 10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd63, 1, 1'b1, 27'd0},
    // Channel values just on and just past a step boundary.
    '{ACT_ACCUM,       10'd1023, 15'd2879,  17'd1,      8'd64,  8'd65,  8'd1,   6'd0,  1, 1'b0, 27'd0},
    '{ACT_READ_COLOR,  10'd1023, 15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd25, 1, 1'b0, 27'd0},
    '{ACT_READ_ORIENT, 10'd1023, 15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b0, 27'd0},
    '{ACT_CLEAR,       10'd5,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b0, 27'd0},
    '{ACT_ACCUM,       10'd5,    15'd23039, 17'd131071, 8'd255, 8'd255, 8'd255, 6'd0,
      200, 1'b0, 27'd0},
    '{ACT_READ_ORIENT, 10'd5,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd7,  1, 1'b1,
      27'd26214200},
    '{ACT_READ_COLOR,  10'd5,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd63, 1, 1'b1,
      27'd200},
    '{ACT_READ_COLOR,  10'd5,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b1, 27'd0},
    // A second clear of a used label empties it again.
    '{ACT_CLEAR,       10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b0, 27'd0},
    '{ACT_READ_ORIENT, 10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd7,  1, 1'b1, 27'd0},
    '{ACT_READ_COLOR,  10'd0,    15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b1, 27'd0},
    // Alternating bit patterns in every field.
    '{ACT_CLEAR,       10'd341,  15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd0,  1, 1'b0, 27'd0},
    '{ACT_ACCUM,       10'd341,  15'h2AAA,  17'h15555,  8'hAA,  8'h55,  8'hAA,  6'h2A, 1, 1'b0, 27'd0},
    '{ACT_READ_ORIENT, 10'd341,  15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd3,  1, 1'b0, 27'd0},
    '{ACT_READ_COLOR,  10'd341,  15'd0,     17'd0,      8'd0,   8'd0,   8'd0,   6'd59, 1, 1'b0, 27'd0}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t  row;
    hist_item_t it;
    cfg_t       c;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row      = directed_rows[i];
      it.act   = row.act;
      it.sp    = row.sp;
      it.angle = row.angle;
      it.mag   = row.mag;
      it.blue  = row.blue;
      it.green = row.green;
      it.red   = row.red;
      it.sel   = row.sel;
      repeat (row.reps) send_item(it, row.typed, row.bin_value);
    end
    settle();

    // Random phases. The first keeps the reset configuration; the others
    // go through the smallest steps, the largest steps and floors, zero
    // steps, and two random settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: c = '{angle_step: 15'd1, blue_min: 8'd0, green_min: 8'd0, red_min: 8'd0,
                 blue_step: 9'd1, green_step: 9'd1, red_step: 9'd1};
        2: c = '{angle_step: 15'd23040, blue_min: 8'd255, green_min: 8'd255, red_min: 8'd255,
                 blue_step: 9'd256, green_step: 9'd256, red_step: 9'd256};
        3: c = '{angle_step: 15'd0, blue_min: 8'd200, green_min: 8'd100, red_min: 8'd1,
                 blue_step: 9'd0, green_step: 9'd0, red_step: 9'd0};
        default: begin
          c.angle_step = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom_range(1, 23040))
                                                     : ANGLE_W'($urandom_range(1, 4000));
          c.blue_min   = CH_W'($urandom_range(0, 255));
          c.green_min  = CH_W'($urandom_range(0, 255));
          c.red_min    = CH_W'($urandom_range(0, 255));
          c.blue_step  = STEP_W'($urandom_range(1, 256));
          c.green_step = STEP_W'($urandom_range(1, 256));
          c.red_step   = STEP_W'($urandom_range(1, 256));
        end
      endcase
      if (p > 0) apply_config(c);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
        // Long receiver stall while items keep coming, to fill the queue.
        if (p == 1 && n == 40) hold_rx = 1'b1;
        send_item(random_item(), 1'b0, '0);
      end
      settle();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side and checking
  // --------------------------------------------------------------------------
  // Each bin read result is compared with the oldest prediction. tready is
  // only lowered when a stall follows, for the same reason as on the sender.
  initial begin
    int unsigned      stall;
    logic [SUM_W-1:0] want;
    logic [SUM_W-1:0] got;
    wait (rst_ni);
    forever begin
      if (hold_rx) begin
        stall   = HOLD_CYCLES;
        hold_rx = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = m_axis_tdata[SUM_W-1:0];
      if (pending_bin_values.size() == 0) begin
        $display("%0t ns: bin_value with no read outstanding, expected none, actual %0d",
                 $time, got);
        error_count++;
      end else begin
        want = pending_bin_values.pop_front();
        if (got !== want) begin
          $display("%0t ns: bin_value mismatch, expected %0d, actual %0d", $time, want, got);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
